>>> src/bfc_pkg.sv
// Shared types and constants for the box/frustum classifier.
// Holds the request and response payload structs, verdict codes and datapath widths.
// No dependencies.
`timescale 1ns / 1ps

package bfc_pkg;

   // Box coordinate width (signed Q12.4 at the default of 16 bits)
   localparam int COORD_WIDTH  = 16;
   localparam int NUM_PLANES   = 6;
   localparam int NUM_AXES     = 3;

   // Plane register layout: three Q2.14 normal components, then a Q12.4 offset
   localparam int PLANE_FIELD_W = 16;
   localparam int OFFSET_FIELD  = 3;
   localparam int OFFSET_SHIFT  = 14;

   // Datapath widths: one normal-by-coordinate product, and a four-term sum
   localparam int PROD_W   = PLANE_FIELD_W + COORD_WIDTH;
   localparam int OFFS_W   = PLANE_FIELD_W + OFFSET_SHIFT;
   localparam int DIST_W   = ((PROD_W > OFFS_W) ? PROD_W : OFFS_W) + 2;

   // Configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = NUM_PLANES * 0 + 4 * PLANE_FIELD_W;

   // Plane mask
   localparam logic [NUM_PLANES-1:0] FULL_MASK = 6'h3F;

   // Verdict codes
   localparam logic [1:0] VERDICT_INSIDE    = 2'd0;
   localparam logic [1:0] VERDICT_INTERSECT = 2'd1;
   localparam logic [1:0] VERDICT_OUTSIDE   = 2'd2;
   localparam logic [1:0] VERDICT_UNUSED    = 2'd3;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] box_min_x;
      logic signed [COORD_WIDTH-1:0] box_min_y;
      logic signed [COORD_WIDTH-1:0] box_min_z;
      logic signed [COORD_WIDTH-1:0] box_max_x;
      logic signed [COORD_WIDTH-1:0] box_max_y;
      logic signed [COORD_WIDTH-1:0] box_max_z;
      logic [NUM_PLANES-1:0]         skip_mask_in;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]            verdict;
      logic [NUM_PLANES-1:0] skip_mask_out;
   } rsp_payload_type;

endpackage

>>> src/box_frustum_classifier_core.sv
// A request moves through the request register, then the product register, then the response register.
// Throughput: one request per cycle while rsp_ready holds; the three-register pipeline (request register,
// product register, response register) advances each stage on its own, so bubbles collapse.
// Every lane has two 16 x COORD_WIDTH multipliers (positive and negative corner) between
// the request and product registers.
// Reset (synchronous, active high) clears all pipeline valids and the six plane registers.
// Depends on bfc_pkg.
`timescale 1ns / 1ps

module box_frustum_classifier_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  bfc_pkg::req_payload_type           req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output bfc_pkg::rsp_payload_type           rsp_payload,
   input  logic                               csr_wr_en,
   input  logic [bfc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bfc_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import bfc_pkg::*;

   // Plane registers
   logic [CSR_DATA_W-1:0] plane_ff [NUM_PLANES];

   // Stage 0: request register
   logic            req_valid_ff, req_valid_in;
   req_payload_type req_data_ff;

   // Stage 1: product register
   logic                     prod_valid_ff, prod_valid_in;
   logic signed [PROD_W-1:0] prod_pos_ff [NUM_PLANES][NUM_AXES];
   logic signed [PROD_W-1:0] prod_neg_ff [NUM_PLANES][NUM_AXES];
   logic signed [PROD_W-1:0] prod_pos_in [NUM_PLANES][NUM_AXES];
   logic signed [PROD_W-1:0] prod_neg_in [NUM_PLANES][NUM_AXES];
   logic [NUM_PLANES-1:0]    prod_mask_ff;

   // Stage 2: response register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   // Per-stage flow control
   logic out_free, prod_free, prod_move, req_free, req_load;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign prod_free = !prod_valid_ff || out_free;
   assign prod_move = prod_valid_ff && out_free;
   assign req_free  = !req_valid_ff || prod_free;
   assign req_load  = req_valid && req_free;

   assign req_ready   = req_free;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // Write plane registers; indexes beyond the last plane are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PLANES; i++) begin
            plane_ff[i] <= '0;
         end
      end else if (csr_wr_en && (csr_index < CSR_INDEX_W'(NUM_PLANES))) begin
         plane_ff[csr_index] <= csr_wdata;
      end
   end

   // Advance valid bits
   always_comb begin
      req_valid_in  = req_free  ? req_valid     : req_valid_ff;
      prod_valid_in = prod_free ? req_valid_ff  : prod_valid_ff;
      rsp_valid_in  = out_free  ? prod_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff  <= 1'b0;
         prod_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         req_valid_ff  <= req_valid_in;
         prod_valid_ff <= prod_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Capture the request
   always_ff @(posedge clock) begin
      if (req_load) begin
         req_data_ff <= req_payload;
      end
   end

   // Pick positive and negative corners by normal sign, multiply each axis
   always_comb begin
      logic signed [COORD_WIDTH-1:0]   lo [NUM_AXES];
      logic signed [COORD_WIDTH-1:0]   hi [NUM_AXES];
      logic signed [PLANE_FIELD_W-1:0] n;
      lo[0] = req_data_ff.box_min_x;
      lo[1] = req_data_ff.box_min_y;
      lo[2] = req_data_ff.box_min_z;
      hi[0] = req_data_ff.box_max_x;
      hi[1] = req_data_ff.box_max_y;
      hi[2] = req_data_ff.box_max_z;
      for (int i = 0; i < NUM_PLANES; i++) begin
         for (int k = 0; k < NUM_AXES; k++) begin
            n = plane_ff[i][k*PLANE_FIELD_W +: PLANE_FIELD_W];
            if (!n[PLANE_FIELD_W-1]) begin
               prod_pos_in[i][k] = PROD_W'(n) * PROD_W'(hi[k]);
               prod_neg_in[i][k] = PROD_W'(n) * PROD_W'(lo[k]);
            end else begin
               prod_pos_in[i][k] = PROD_W'(n) * PROD_W'(lo[k]);
               prod_neg_in[i][k] = PROD_W'(n) * PROD_W'(hi[k]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_ff && prod_free) begin
         prod_pos_ff  <= prod_pos_in;
         prod_neg_ff  <= prod_neg_in;
         prod_mask_ff <= req_data_ff.skip_mask_in;
      end
   end

   // Sum distances, test signs and resolve the plane scan in order
   always_comb begin
      logic signed [DIST_W-1:0]        dist_pos;
      logic signed [DIST_W-1:0]        dist_neg;
      logic signed [DIST_W-1:0]        offs;
      logic signed [PLANE_FIELD_W-1:0] w;
      logic [NUM_PLANES-1:0]           mask;
      logic                            stop;
      logic                            straddle;
      w        = '0;
      offs     = '0;
      dist_pos = '0;
      dist_neg = '0;
      mask     = prod_mask_ff;
      stop     = 1'b0;
      straddle = 1'b0;
      for (int i = 0; i < NUM_PLANES; i++) begin
         w        = plane_ff[i][OFFSET_FIELD*PLANE_FIELD_W +: PLANE_FIELD_W];
         offs     = DIST_W'(w);
         offs     = offs <<< OFFSET_SHIFT;
         dist_pos = offs;
         dist_neg = offs;
         for (int k = 0; k < NUM_AXES; k++) begin
            dist_pos = dist_pos + DIST_W'(prod_pos_ff[i][k]);
            dist_neg = dist_neg + DIST_W'(prod_neg_ff[i][k]);
         end
         // Planes after the deciding one are not looked at
         if (!stop && !prod_mask_ff[i]) begin
            if (dist_pos[DIST_W-1]) begin
               stop = 1'b1;
            end else if (dist_neg[DIST_W-1]) begin
               straddle = 1'b1;
            end else begin
               mask[i] = 1'b1;
            end
         end
      end
      rsp_data_in.skip_mask_out = mask;
      if (stop) begin
         rsp_data_in.verdict = VERDICT_OUTSIDE;
      end else if (straddle) begin
         rsp_data_in.verdict = VERDICT_INTERSECT;
      end else begin
         rsp_data_in.verdict = VERDICT_INSIDE;
      end
   end

   always_ff @(posedge clock) begin
      if (prod_move) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

>>> src/bfc_checker.sv
// Port-level checks for box_frustum_classifier_core, attached by bind.
// Depends on bfc_pkg.
`timescale 1ns / 1ps

module bfc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input bfc_pkg::req_payload_type        req_payload,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input bfc_pkg::rsp_payload_type        rsp_payload,
   input logic                            csr_wr_en,
   input logic [bfc_pkg::CSR_INDEX_W-1:0] csr_index,
   input logic [bfc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import bfc_pkg::*;

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed or dropped");

   // Drop all responses coming out of reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // Inside means every plane ended up passed
   a_inside_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.verdict == VERDICT_INSIDE |->
         rsp_payload.skip_mask_out == FULL_MASK)
      else $error("inside verdict without a full mask");

   // Intersecting leaves at least one plane open, and the spare code never shows
   a_verdict_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.verdict != VERDICT_UNUSED &&
         (rsp_payload.verdict != VERDICT_INTERSECT ||
          rsp_payload.skip_mask_out != FULL_MASK))
      else $error("verdict and mask disagree");

endmodule

bind box_frustum_classifier_core bfc_checker u_bfc_checker (.*);

>>> bench/tb_top.sv
// Self-checking bench for box_frustum_classifier_core: box requests against six plane registers.
// Predicts each verdict and plane mask in the bench and compares them with the responses in order.
// Depends on bfc_pkg and box_frustum_classifier_core.
`timescale 1ns / 1ps

module tb_top;
   import bfc_pkg::*;

   // Plane register indexes, plus two spare indexes the block must ignore
   localparam logic [CSR_INDEX_W-1:0] PLANE_LEFT   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] PLANE_RIGHT  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] PLANE_BOTTOM = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] PLANE_TOP    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] PLANE_NEAR   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] PLANE_FAR    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;

   // 1.0 in Q2.14
   localparam int UNIT = 16384;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   req_payload_type        req_payload;
   logic                   rsp_valid;
   logic                   rsp_ready;
   rsp_payload_type        rsp_payload;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   logic [63:0]     plane_mirror [NUM_PLANES];
   rsp_payload_type pending_verdicts [$];
   rsp_payload_type oldest_verdict;
   int              mismatch_count;
   int              sender_idle_pct;
   int              receiver_idle_pct;
   int              stall_cycles;

   box_frustum_classifier_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Give up well past the slowest legal run
   initial begin
      #5_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // Classify one box against the mirrored planes
   function automatic rsp_payload_type classify_box(input req_payload_type box);
      rsp_payload_type       verdict_out;
      logic [NUM_PLANES-1:0] mask;
      longint                lo [NUM_AXES];
      longint                hi [NUM_AXES];
      longint                normal;
      longint                dist_pos;
      longint                dist_neg;
      logic                  decided;
      int                    p;
      int                    k;
      lo[0] = $signed(box.box_min_x);
      lo[1] = $signed(box.box_min_y);
      lo[2] = $signed(box.box_min_z);
      hi[0] = $signed(box.box_max_x);
      hi[1] = $signed(box.box_max_y);
      hi[2] = $signed(box.box_max_z);
      mask = box.skip_mask_in;
      verdict_out.verdict = VERDICT_INSIDE;
      decided = 1'b0;
      if (mask != FULL_MASK) begin
         for (p = 0; p < NUM_PLANES; p++) begin
            if (!decided && !mask[p]) begin
               dist_pos = longint'($signed(plane_mirror[p][63:48])) * UNIT;
               dist_neg = dist_pos;
               // Positive corner takes max where the normal is non-negative
               for (k = 0; k < NUM_AXES; k++) begin
                  normal = $signed(plane_mirror[p][16*k +: 16]);
                  if (normal >= 0) begin
                     dist_pos += normal * hi[k];
                     dist_neg += normal * lo[k];
                  end else begin
                     dist_pos += normal * lo[k];
                     dist_neg += normal * hi[k];
                  end
               end
               if (dist_pos < 0) begin
                  verdict_out.verdict = VERDICT_OUTSIDE;
                  decided = 1'b1;
               end else if (dist_neg < 0) begin
                  verdict_out.verdict = VERDICT_INTERSECT;
               end else begin
                  mask[p] = 1'b1;
               end
            end
         end
      end
      verdict_out.skip_mask_out = mask;
      return verdict_out;
   endfunction

   function automatic logic [63:0] pack_plane(input int nx, input int ny, input int nz,
                                              input int offs);
      return {offs[15:0], nz[15:0], ny[15:0], nx[15:0]};
   endfunction

   function automatic logic [63:0] random_plane(input int offs_reach);
      int offs;
      offs = int'($urandom_range(2 * offs_reach)) - offs_reach;
      return {offs[15:0], 16'($urandom), 16'($urandom), 16'($urandom)};
   endfunction

   function automatic req_payload_type make_box(input int min_x, input int min_y,
                                                input int min_z, input int max_x,
                                                input int max_y, input int max_z,
                                                input logic [NUM_PLANES-1:0] mask);
      req_payload_type box;
      box.box_min_x    = min_x[COORD_WIDTH-1:0];
      box.box_min_y    = min_y[COORD_WIDTH-1:0];
      box.box_min_z    = min_z[COORD_WIDTH-1:0];
      box.box_max_x    = max_x[COORD_WIDTH-1:0];
      box.box_max_y    = max_y[COORD_WIDTH-1:0];
      box.box_max_z    = max_z[COORD_WIDTH-1:0];
      box.skip_mask_in = mask;
      return box;
   endfunction

   // Mostly well-formed boxes around the origin, some raw noise and some inverted boxes
   function automatic req_payload_type random_box(input int reach);
      req_payload_type       box;
      int                    center [NUM_AXES];
      int                    half [NUM_AXES];
      int                    k;
      int                    shape;
      logic [NUM_PLANES-1:0] mask;
      shape = $urandom_range(9);
      for (k = 0; k < NUM_AXES; k++) begin
         center[k] = int'($urandom_range(2 * reach)) - reach;
         half[k]   = $urandom_range(reach / 2);
         if (shape == 1) half[k] = -half[k];
      end
      case ($urandom_range(9))
         0:       mask = FULL_MASK;
         1, 2:    mask = 6'($urandom);
         default: mask = '0;
      endcase
      if (shape == 0) begin
         box = req_payload_type'({$urandom, $urandom, $urandom, 6'($urandom)});
         box.skip_mask_in = mask;
      end else begin
         box = make_box(center[0] - half[0], center[1] - half[1], center[2] - half[2],
                        center[0] + half[0], center[1] + half[1], center[2] + half[2], mask);
      end
      return box;
   endfunction

   // Offer one request and record its verdict when it is accepted
   task automatic offer_box(input req_payload_type box);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid   = 1'b1;
      req_payload = box;
      do @(posedge clock); while (!req_ready);
      pending_verdicts.push_back(classify_box(box));
   endtask

   // Drop valid and wait until every response is back
   task automatic drain_requests();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_plane(input logic [CSR_INDEX_W-1:0] idx, input logic [63:0] value);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      if (idx < NUM_PLANES) plane_mirror[idx] = value;
   endtask

   // Axis-aligned cube frustum spanning -half..half on every axis
   task automatic load_cube(input int half);
      write_plane(PLANE_LEFT,   pack_plane(UNIT, 0, 0, half));
      write_plane(PLANE_RIGHT,  pack_plane(-UNIT, 0, 0, half));
      write_plane(PLANE_BOTTOM, pack_plane(0, UNIT, 0, half));
      write_plane(PLANE_TOP,    pack_plane(0, -UNIT, 0, half));
      write_plane(PLANE_NEAR,   pack_plane(0, 0, UNIT, half));
      write_plane(PLANE_FAR,    pack_plane(0, 0, -UNIT, half));
   endtask

   // With all planes zero every point sits on the plane, so everything passes
   task automatic test_reset_planes();
      offer_box(make_box(0, 0, 0, 0, 0, 0, '0));
      offer_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767, 6'h15));
      offer_box(make_box(32767, 32767, 32767, -32768, -32768, -32768, FULL_MASK));
      drain_requests();
   endtask

   // Zero normal: the offset sign alone decides; spare indexes must not land anywhere
   task automatic test_zero_normal();
      write_plane(PLANE_LEFT, pack_plane(0, 0, 0, -1));
      write_plane(CSR_SPARE_LO, 64'hFFFF_FFFF_FFFF_FFFF);
      write_plane(CSR_SPARE_HI, 64'h8000_8000_8000_8000);
      offer_box(make_box(0, 0, 0, 0, 0, 0, '0));
      offer_box(make_box(0, 0, 0, 0, 0, 0, 6'h01));
      offer_box(make_box(-5, -5, -5, 5, 5, 5, 6'h2A));
      drain_requests();
   endtask

   task automatic test_directed_cube();
      load_cube(1000);
      offer_box(make_box(-100, -100, -100, 100, 100, 100, '0));
      offer_box(make_box(-1200, -10, -10, 0, 10, 10, '0));
      offer_box(make_box(-2000, 0, 0, -1100, 0, 0, '0));
      // touching the plane exactly counts as in front
      offer_box(make_box(-1000, 0, 0, -1000, 0, 0, '0));
      // inverted corners are used as given
      offer_box(make_box(500, 500, 500, -500, -500, -500, '0));
      offer_box(make_box(1500, 0, 0, -1500, 0, 0, '0));
      offer_box(make_box(-2000, -2000, -2000, -1100, -1100, -1100, FULL_MASK));
      offer_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767, '0));
      // straddles left, then lies beyond far: outside with a partial mask
      offer_box(make_box(-1200, -10, 1100, 0, 10, 1200, '0));
      offer_box(make_box(-1200, -10, 1100, 0, 10, 1200, 6'h20));
      drain_requests();
   endtask

   // Extreme normal and offset codes against extreme corners
   task automatic test_extreme_planes();
      write_plane(PLANE_LEFT,   64'h7FFF_7FFF_7FFF_7FFF);
      write_plane(PLANE_RIGHT,  64'h8000_8000_8000_8000);
      write_plane(PLANE_BOTTOM, 64'h7FFF_8000_7FFF_8000);
      write_plane(PLANE_TOP,    64'h8000_7FFF_8000_7FFF);
      write_plane(PLANE_NEAR,   64'h0000_8000_0000_7FFF);
      write_plane(PLANE_FAR,    64'hFFFF_0001_FFFF_0001);
      offer_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767, '0));
      offer_box(make_box(32767, 32767, 32767, 32767, 32767, 32767, '0));
      offer_box(make_box(-32768, -32768, -32768, -32768, -32768, -32768, 6'h01));
      offer_box(make_box(0, 0, 0, 0, 0, 0, 6'h03));
      drain_requests();
   endtask

   task automatic test_random_cube();
      int sizes [3];
      int s;
      int n;
      sizes[0] = 64;
      sizes[1] = $urandom_range(200, 4000);
      sizes[2] = 32767;
      for (s = 0; s < 3; s++) begin
         load_cube(sizes[s]);
         for (n = 0; n < 100; n++)
            offer_box(random_box((sizes[s] > 8000) ? 16000 : 2 * sizes[s]));
         drain_requests();
      end
   endtask

   task automatic test_random_planes();
      int c;
      int p;
      int n;
      for (c = 0; c < 3; c++) begin
         for (p = 0; p < NUM_PLANES; p++)
            write_plane(CSR_INDEX_W'(p), random_plane((c == 0) ? 32767 : 2000));
         for (n = 0; n < 100; n++) offer_box(random_box(4000));
         drain_requests();
      end
   endtask

   // Hold the response side off long enough to back the pipeline up into the request side
   task automatic test_backpressure();
      int n;
      load_cube(800);
      @(posedge clock);
      stall_cycles = 60;
      for (n = 0; n < 40; n++) offer_box(random_box(1600));
      drain_requests();
   endtask

   task automatic test_free_running();
      int c;
      int p;
      int n;
      for (c = 0; c < 2; c++) begin
         for (p = 0; p < NUM_PLANES; p++) write_plane(CSR_INDEX_W'(p), random_plane(500));
         for (n = 0; n < 100; n++) offer_box(random_box(3000));
         drain_requests();
      end
   endtask

   // Response side: random stalls, or a counted hold-off when one is requested
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_cycles > 0) begin
            rsp_ready = 1'b0;
            stall_cycles--;
         end else begin
            rsp_ready = ($urandom_range(99) >= receiver_idle_pct);
         end
      end
   end

   // Compare each accepted response with the oldest outstanding verdict
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_verdicts.size() == 0) begin
            $display("%0t: unexpected response verdict %0d mask %02h", $time,
                     rsp_payload.verdict, rsp_payload.skip_mask_out);
            mismatch_count++;
         end else begin
            oldest_verdict = pending_verdicts.pop_front();
            if (rsp_payload.verdict !== oldest_verdict.verdict) begin
               $display("%0t: verdict expected %0d actual %0d", $time,
                        oldest_verdict.verdict, rsp_payload.verdict);
               mismatch_count++;
            end
            if (rsp_payload.skip_mask_out !== oldest_verdict.skip_mask_out) begin
               $display("%0t: skip mask expected %02h actual %02h", $time,
                        oldest_verdict.skip_mask_out, rsp_payload.skip_mask_out);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_payload       = '0;
      csr_wr_en         = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;
      mismatch_count    = 0;
      stall_cycles      = 0;
      sender_idle_pct   = 36;
      receiver_idle_pct = 72;
      for (int p = 0; p < NUM_PLANES; p++) plane_mirror[p] = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_planes();
      test_zero_normal();
      test_directed_cube();
      test_extreme_planes();
      test_random_cube();

      sender_idle_pct   = 72;
      receiver_idle_pct = 36;
      test_random_planes();

      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      test_backpressure();
      test_free_running();

      drain_requests();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

>>> sim.f
src/bfc_pkg.sv
src/box_frustum_classifier_core.sv
src/bfc_checker.sv
bench/tb_top.sv
